@@ design/lome_pkg.sv @@
// shared types and constants for the limit order matching engine
`default_nettype none

package lome_pkg;

    localparam int PRICE_LEVELS = 1024;
    localparam int PRICE_BITS   = 10;
    localparam int LVL_BITS     = PRICE_BITS + 1;
    localparam int ORDER_SLOTS  = 64;
    localparam int SLOT_BITS    = 6;
    localparam int QTY_BITS     = 20;
    localparam int ID_BITS      = 16;
    localparam int TOTAL_BITS   = 26;
    localparam int ASK_BITS     = 17;

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [QTY_BITS-1:0]   qty_t;
    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [TOTAL_BITS-1:0] total_t;
    typedef logic [LVL_BITS-1:0]   lvl_addr_t;

    localparam slot_t  SLOT_LAST = slot_t'(ORDER_SLOTS - 1);
    localparam price_t PRICE_MAX = price_t'(PRICE_LEVELS - 1);
    localparam logic [ASK_BITS-1:0] EMPTY_ASK_RESET = 17'd99999;

    localparam logic [1:0] REQ_BUY    = 2'd0;
    localparam logic [1:0] REQ_SELL   = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    localparam logic ADDR_EMPTY_ASK = 1'b0;

    // resting order entry
    typedef struct packed {
        logic   side;
        qty_t   qty;
        price_t price;
        id_t    id;
        slot_t  next;
    } ord_entry_t;

    // price level entry: fifo head, tail and total quantity
    typedef struct packed {
        slot_t  head;
        slot_t  tail;
        total_t total;
    } lvl_entry_t;

endpackage

`default_nettype wire

@@ design/limit_order_matching_engine_core.sv @@
// limit order matching engine core: order store, level table and match sequencer
//
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_ready  | req_type, quantity, price, target_order
// out      | output    | out_valid/out_ready| is_quote, trade and quote fields, last
// cfg      | input     | apb psel/penable   | empty_ask_price at byte address 0
//
// one request at a time; a request runs the match check, a level and head order read
// per trade, the rest steps when a remainder rests behind other orders, and the
// quote reads; a cancel search skips free slots and reads each resting slot, then walks
// the level list to the predecessor; a best rescan after a best level empties reads the
// levels of that side one after another; the single read port of each memory orders
// these steps. after reset a clearing pass sweeps the level table while in_ready is low.
// a stalled out channel holds the sequencer at the next result; a finished quote may
// wait in the output register while the next request is taken.
`default_nettype none

module limit_order_matching_engine_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     req_type,
    input  wire logic [lome_pkg::QTY_BITS-1:0]  quantity,
    input  wire logic [lome_pkg::PRICE_BITS-1:0] price,
    input  wire logic [lome_pkg::ID_BITS-1:0]   target_order,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                is_quote,
    output logic [lome_pkg::QTY_BITS-1:0]       trade_qty,
    output logic [lome_pkg::PRICE_BITS-1:0]     trade_price,
    output logic [lome_pkg::TOTAL_BITS-1:0]     bid_qty,
    output logic [lome_pkg::PRICE_BITS-1:0]     bid_price,
    output logic [lome_pkg::TOTAL_BITS-1:0]     ask_qty,
    output logic [lome_pkg::ASK_BITS-1:0]       ask_price,
    output logic                                rejected,
    output logic                                last
);

    localparam logic [4:0] ST_CLR    = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_MCHK   = 5'd2;
    localparam logic [4:0] ST_MLV    = 5'd3;
    localparam logic [4:0] ST_MORD   = 5'd4;
    localparam logic [4:0] ST_REST   = 5'd5;
    localparam logic [4:0] ST_RLV    = 5'd6;
    localparam logic [4:0] ST_RTL    = 5'd7;
    localparam logic [4:0] ST_CRD    = 5'd8;
    localparam logic [4:0] ST_CCHK   = 5'd9;
    localparam logic [4:0] ST_CLV    = 5'd10;
    localparam logic [4:0] ST_CWALK  = 5'd11;
    localparam logic [4:0] ST_CFIX   = 5'd12;
    localparam logic [4:0] ST_SRD    = 5'd13;
    localparam logic [4:0] ST_SCHK   = 5'd14;
    localparam logic [4:0] ST_QRB    = 5'd15;
    localparam logic [4:0] ST_QRA    = 5'd16;
    localparam logic [4:0] ST_QOUT   = 5'd17;

    // memories
    lome_pkg::ord_entry_t ord_mem [lome_pkg::ORDER_SLOTS];
    lome_pkg::lvl_entry_t lvl_mem [2 * lome_pkg::PRICE_LEVELS];

    logic                 o_we, o_re;
    lome_pkg::slot_t      o_waddr, o_raddr;
    lome_pkg::ord_entry_t o_wdata, o_rdata;
    logic                 l_we, l_re;
    lome_pkg::lvl_addr_t  l_waddr, l_raddr;
    lome_pkg::lvl_entry_t l_wdata, l_rdata;

    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            ord_mem[o_waddr] <= o_wdata;
        end
        if (o_re)
        begin
            o_rdata <= ord_mem[o_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            lvl_mem[l_waddr] <= l_wdata;
        end
        if (l_re)
        begin
            l_rdata <= lvl_mem[l_raddr];
        end
    end

    // control and book registers
    logic [4:0]               state_reg, state_next, ret_reg, ret_next;
    logic [1:0]               typ_reg, typ_next;
    lome_pkg::qty_t           qty_reg, qty_next;
    lome_pkg::price_t         price_reg, price_next;
    lome_pkg::id_t            id_reg, id_next, target_reg, target_next;
    lome_pkg::id_t            next_id_reg, next_id_next;
    logic                     rej_reg, rej_next;
    logic                     bid_v_reg, bid_v_next, ask_v_reg, ask_v_next;
    lome_pkg::price_t         bid_p_reg, bid_p_next, ask_p_reg, ask_p_next;
    logic [lome_pkg::ASK_BITS-1:0] empty_ask_reg, empty_ask_next;
    logic [lome_pkg::ORDER_SLOTS-1:0] free_reg, free_next;
    lome_pkg::lvl_addr_t      clr_reg, clr_next;
    lome_pkg::price_t         ptr_reg, ptr_next;
    logic                     scan_side_reg, scan_side_next;
    lome_pkg::slot_t          slot_reg, slot_next, cur_reg, cur_next, prev_reg, prev_next;
    lome_pkg::lvl_entry_t     lv_reg, lv_next;
    lome_pkg::ord_entry_t     cent_reg, cent_next;
    lome_pkg::total_t         bid_tot_reg, bid_tot_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic                     is_quote_reg, is_quote_next;
    lome_pkg::qty_t           trade_qty_reg, trade_qty_next;
    lome_pkg::price_t         trade_price_reg, trade_price_next;
    lome_pkg::total_t         bid_qty_reg, bid_qty_next, ask_qty_reg, ask_qty_next;
    lome_pkg::price_t         bid_price_reg, bid_price_next;
    logic [lome_pkg::ASK_BITS-1:0] ask_price_reg, ask_price_next;
    logic                     rejected_reg, rejected_next;

    logic                     out_free, out_load;
    logic                     side;
    lome_pkg::slot_t          alloc;
    logic                     alloc_ok;
    lome_pkg::qty_t           take;
    lome_pkg::price_t         mp;
    lome_pkg::lvl_entry_t     lnew;
    logic                     cfg_wr;

    assign side     = typ_reg[0];
    assign out_free = !out_valid_reg || out_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign mp       = (side == 1'b0) ? ask_p_reg : bid_p_reg;

    // lowest free slot, slot zero is the null link
    always_comb
    begin
        alloc    = '0;
        alloc_ok = 1'b0;
        for (int i = lome_pkg::ORDER_SLOTS - 1; i >= 1; i--)
        begin
            if (free_reg[i])
            begin
                alloc    = lome_pkg::slot_t'(i);
                alloc_ok = 1'b1;
            end
        end
    end

    assign take = (o_rdata.qty < qty_reg) ? o_rdata.qty : qty_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        typ_next        = typ_reg;
        qty_next        = qty_reg;
        price_next      = price_reg;
        id_next         = id_reg;
        target_next     = target_reg;
        next_id_next    = next_id_reg;
        rej_next        = rej_reg;
        bid_v_next      = bid_v_reg;
        bid_p_next      = bid_p_reg;
        ask_v_next      = ask_v_reg;
        ask_p_next      = ask_p_reg;
        empty_ask_next  = empty_ask_reg;
        free_next       = free_reg;
        clr_next        = clr_reg;
        ptr_next        = ptr_reg;
        scan_side_next  = scan_side_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        lv_next         = lv_reg;
        cent_next       = cent_reg;
        bid_tot_next    = bid_tot_reg;
        out_load        = 1'b0;
        is_quote_next   = is_quote_reg;
        trade_qty_next  = trade_qty_reg;
        trade_price_next = trade_price_reg;
        bid_qty_next    = bid_qty_reg;
        bid_price_next  = bid_price_reg;
        ask_qty_next    = ask_qty_reg;
        ask_price_next  = ask_price_reg;
        rejected_next   = rejected_reg;
        o_we    = 1'b0;
        o_re    = 1'b0;
        o_waddr = '0;
        o_raddr = '0;
        o_wdata = o_rdata;
        l_we    = 1'b0;
        l_re    = 1'b0;
        l_waddr = '0;
        l_raddr = '0;
        l_wdata = '0;
        lnew    = '0;

        if (cfg_wr && paddr[2] == lome_pkg::ADDR_EMPTY_ASK)
        begin
            empty_ask_next = pwdata[lome_pkg::ASK_BITS-1:0];
        end

        case (state_reg)
            ST_CLR:
            begin
                l_we     = 1'b1;
                l_waddr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    typ_next     = req_type;
                    qty_next     = quantity;
                    price_next   = price;
                    target_next  = target_order;
                    id_next      = next_id_reg;
                    next_id_next = next_id_reg + 1'b1;
                    rej_next     = 1'b0;
                    slot_next    = lome_pkg::slot_t'(1);
                    if (req_type == lome_pkg::REQ_BUY || req_type == lome_pkg::REQ_SELL)
                    begin
                        state_next = (quantity != '0) ? ST_MCHK : ST_QRB;
                    end
                    else if (req_type == lome_pkg::REQ_CANCEL)
                    begin
                        state_next = ST_CRD;
                    end
                    else
                    begin
                        state_next = ST_QRB;
                    end
                end
            end
            // match against best opposite level
            ST_MCHK:
            begin
                if (qty_reg == '0)
                begin
                    state_next = ST_QRB;
                end
                else if ((side == 1'b0 && ask_v_reg && ask_p_reg <= price_reg) ||
                         (side == 1'b1 && bid_v_reg && bid_p_reg >= price_reg))
                begin
                    l_re       = 1'b1;
                    l_raddr    = {~side, mp};
                    state_next = ST_MLV;
                end
                else
                begin
                    state_next = ST_REST;
                end
            end
            ST_MLV:
            begin
                lv_next    = l_rdata;
                o_re       = 1'b1;
                o_raddr    = l_rdata.head;
                state_next = ST_MORD;
            end
            ST_MORD:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    is_quote_next    = 1'b0;
                    trade_qty_next   = take;
                    trade_price_next = mp;
                    bid_qty_next     = '0;
                    bid_price_next   = '0;
                    ask_qty_next     = '0;
                    ask_price_next   = '0;
                    rejected_next    = 1'b0;
                    qty_next         = qty_reg - take;
                    l_we             = 1'b1;
                    l_waddr          = {~side, mp};
                    lnew.head        = lv_reg.head;
                    lnew.tail        = lv_reg.tail;
                    lnew.total       = lv_reg.total - lome_pkg::total_t'(take);
                    state_next       = ST_MCHK;
                    if (o_rdata.qty == take)
                    begin
                        free_next[lv_reg.head] = 1'b1;
                        lnew.head = o_rdata.next;
                        if (o_rdata.next == '0)
                        begin
                            lnew = '0;
                            // best level emptied, rescan the opposite side
                            ret_next       = ST_MCHK;
                            scan_side_next = ~side;
                            if (side == 1'b1)
                            begin
                                if (mp == '0)
                                begin
                                    bid_v_next = 1'b0;
                                end
                                else
                                begin
                                    ptr_next   = mp - 1'b1;
                                    state_next = ST_SRD;
                                end
                            end
                            else
                            begin
                                if (mp == lome_pkg::PRICE_MAX)
                                begin
                                    ask_v_next = 1'b0;
                                end
                                else
                                begin
                                    ptr_next   = mp + 1'b1;
                                    state_next = ST_SRD;
                                end
                            end
                        end
                    end
                    else
                    begin
                        o_we        = 1'b1;
                        o_waddr     = lv_reg.head;
                        o_wdata     = o_rdata;
                        o_wdata.qty = o_rdata.qty - take;
                    end
                    l_wdata = lnew;
                end
            end
            // rest the remainder at the tail of its level
            ST_REST:
            begin
                if (!alloc_ok)
                begin
                    rej_next   = 1'b1;
                    state_next = ST_QRB;
                end
                else
                begin
                    slot_next  = alloc;
                    l_re       = 1'b1;
                    l_raddr    = {side, price_reg};
                    state_next = ST_RLV;
                end
            end
            ST_RLV:
            begin
                o_we            = 1'b1;
                o_waddr         = slot_reg;
                o_wdata.side    = side;
                o_wdata.qty     = qty_reg;
                o_wdata.price   = price_reg;
                o_wdata.id      = id_reg;
                o_wdata.next    = '0;
                free_next[slot_reg] = 1'b0;
                l_we            = 1'b1;
                l_waddr         = {side, price_reg};
                if (l_rdata.head == '0)
                begin
                    l_wdata.head  = slot_reg;
                    l_wdata.tail  = slot_reg;
                    l_wdata.total = lome_pkg::total_t'(qty_reg);
                    state_next    = ST_QRB;
                end
                else
                begin
                    l_wdata.head  = l_rdata.head;
                    l_wdata.tail  = slot_reg;
                    l_wdata.total = l_rdata.total + lome_pkg::total_t'(qty_reg);
                    o_re          = 1'b1;
                    o_raddr       = l_rdata.tail;
                    cur_next      = l_rdata.tail;
                    state_next    = ST_RTL;
                end
                if (side == 1'b0 && (!bid_v_reg || price_reg > bid_p_reg))
                begin
                    bid_v_next = 1'b1;
                    bid_p_next = price_reg;
                end
                if (side == 1'b1 && (!ask_v_reg || price_reg < ask_p_reg))
                begin
                    ask_v_next = 1'b1;
                    ask_p_next = price_reg;
                end
            end
            ST_RTL:
            begin
                o_we         = 1'b1;
                o_waddr      = cur_reg;
                o_wdata      = o_rdata;
                o_wdata.next = slot_reg;
                state_next   = ST_QRB;
            end
            // cancel: search slots in order for the id
            ST_CRD:
            begin
                if (free_reg[slot_reg])
                begin
                    if (slot_reg == lome_pkg::SLOT_LAST)
                    begin
                        state_next = ST_QRB;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
                else
                begin
                    o_re       = 1'b1;
                    o_raddr    = slot_reg;
                    state_next = ST_CCHK;
                end
            end
            ST_CCHK:
            begin
                if (o_rdata.id == target_reg)
                begin
                    cent_next  = o_rdata;
                    l_re       = 1'b1;
                    l_raddr    = {o_rdata.side, o_rdata.price};
                    state_next = ST_CLV;
                end
                else if (slot_reg == lome_pkg::SLOT_LAST)
                begin
                    state_next = ST_QRB;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_CLV:
            begin
                lv_next   = l_rdata;
                prev_next = '0;
                if (l_rdata.head == slot_reg)
                begin
                    state_next = ST_CFIX;
                end
                else
                begin
                    o_re       = 1'b1;
                    o_raddr    = l_rdata.head;
                    cur_next   = l_rdata.head;
                    state_next = ST_CWALK;
                end
            end
            // walk the level fifo to the predecessor
            ST_CWALK:
            begin
                if (o_rdata.next == slot_reg)
                begin
                    o_we         = 1'b1;
                    o_waddr      = cur_reg;
                    o_wdata      = o_rdata;
                    o_wdata.next = cent_reg.next;
                    prev_next    = cur_reg;
                    state_next   = ST_CFIX;
                end
                else
                begin
                    o_re     = 1'b1;
                    o_raddr  = o_rdata.next;
                    cur_next = o_rdata.next;
                end
            end
            ST_CFIX:
            begin
                lnew.head  = (prev_reg == '0) ? cent_reg.next : lv_reg.head;
                lnew.tail  = (lv_reg.tail == slot_reg) ? prev_reg : lv_reg.tail;
                lnew.total = lv_reg.total - lome_pkg::total_t'(cent_reg.qty);
                state_next = ST_QRB;
                if (lnew.head == '0)
                begin
                    lnew = '0;
                    ret_next       = ST_QRB;
                    scan_side_next = cent_reg.side;
                    if (cent_reg.side == 1'b0 && bid_v_reg && bid_p_reg == cent_reg.price)
                    begin
                        if (cent_reg.price == '0)
                        begin
                            bid_v_next = 1'b0;
                        end
                        else
                        begin
                            ptr_next   = cent_reg.price - 1'b1;
                            state_next = ST_SRD;
                        end
                    end
                    if (cent_reg.side == 1'b1 && ask_v_reg && ask_p_reg == cent_reg.price)
                    begin
                        if (cent_reg.price == lome_pkg::PRICE_MAX)
                        begin
                            ask_v_next = 1'b0;
                        end
                        else
                        begin
                            ptr_next   = cent_reg.price + 1'b1;
                            state_next = ST_SRD;
                        end
                    end
                end
                l_we    = 1'b1;
                l_waddr = {cent_reg.side, cent_reg.price};
                l_wdata = lnew;
                free_next[slot_reg] = 1'b1;
            end
            // best price rescan: read a level, then check it and step on to the next
            ST_SRD:
            begin
                l_re       = 1'b1;
                l_raddr    = {scan_side_reg, ptr_reg};
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (l_rdata.head != '0)
                begin
                    if (scan_side_reg == 1'b0)
                    begin
                        bid_v_next = 1'b1;
                        bid_p_next = ptr_reg;
                    end
                    else
                    begin
                        ask_v_next = 1'b1;
                        ask_p_next = ptr_reg;
                    end
                    state_next = ret_reg;
                end
                else if (scan_side_reg == 1'b0)
                begin
                    if (ptr_reg == '0)
                    begin
                        bid_v_next = 1'b0;
                        state_next = ret_reg;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_SRD;
                    end
                end
                else
                begin
                    if (ptr_reg == lome_pkg::PRICE_MAX)
                    begin
                        ask_v_next = 1'b0;
                        state_next = ret_reg;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_SRD;
                    end
                end
            end
            // quote: read both best level totals
            ST_QRB:
            begin
                l_re       = 1'b1;
                l_raddr    = {1'b0, bid_p_reg};
                state_next = ST_QRA;
            end
            ST_QRA:
            begin
                bid_tot_next = l_rdata.total;
                l_re         = 1'b1;
                l_raddr      = {1'b1, ask_p_reg};
                state_next   = ST_QOUT;
            end
            ST_QOUT:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    is_quote_next    = 1'b1;
                    trade_qty_next   = '0;
                    trade_price_next = '0;
                    bid_qty_next     = bid_v_reg ? bid_tot_reg : '0;
                    bid_price_next   = bid_v_reg ? bid_p_reg : '0;
                    ask_qty_next     = ask_v_reg ? l_rdata.total : '0;
                    ask_price_next   = ask_v_reg ?
                        {{(lome_pkg::ASK_BITS - lome_pkg::PRICE_BITS){1'b0}}, ask_p_reg} :
                        empty_ask_reg;
                    rejected_next    = rej_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            next_id_reg   <= lome_pkg::id_t'(1);
            bid_v_reg     <= 1'b0;
            ask_v_reg     <= 1'b0;
            bid_p_reg     <= '0;
            ask_p_reg     <= '0;
            empty_ask_reg <= lome_pkg::EMPTY_ASK_RESET;
            free_reg      <= {{(lome_pkg::ORDER_SLOTS - 1){1'b1}}, 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            next_id_reg   <= next_id_next;
            bid_v_reg     <= bid_v_next;
            ask_v_reg     <= ask_v_next;
            bid_p_reg     <= bid_p_next;
            ask_p_reg     <= ask_p_next;
            empty_ask_reg <= empty_ask_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        ret_reg         <= ret_next;
        typ_reg         <= typ_next;
        qty_reg         <= qty_next;
        price_reg       <= price_next;
        id_reg          <= id_next;
        target_reg      <= target_next;
        rej_reg         <= rej_next;
        ptr_reg         <= ptr_next;
        scan_side_reg   <= scan_side_next;
        slot_reg        <= slot_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        lv_reg          <= lv_next;
        cent_reg        <= cent_next;
        bid_tot_reg     <= bid_tot_next;
        is_quote_reg    <= is_quote_next;
        trade_qty_reg   <= trade_qty_next;
        trade_price_reg <= trade_price_next;
        bid_qty_reg     <= bid_qty_next;
        bid_price_reg   <= bid_price_next;
        ask_qty_reg     <= ask_qty_next;
        ask_price_reg   <= ask_price_next;
        rejected_reg    <= rejected_next;
    end

    // ports
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign is_quote    = is_quote_reg;
    assign trade_qty   = trade_qty_reg;
    assign trade_price = trade_price_reg;
    assign bid_qty     = bid_qty_reg;
    assign bid_price   = bid_price_reg;
    assign ask_qty     = ask_qty_reg;
    assign ask_price   = ask_price_reg;
    assign rejected    = rejected_reg;
    assign last        = is_quote_reg;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == lome_pkg::ADDR_EMPTY_ASK) ?
                         {{(32 - lome_pkg::ASK_BITS){1'b0}}, empty_ask_reg} : 32'd0;

endmodule

`default_nettype wire

@@ dv/book_checker.sv @@
// order book checker: predicts trades and quotes from accepted requests and compares results
`default_nettype none

module book_checker
    import lome_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    input  wire logic                pready,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [1:0]          req_type,
    input  wire qty_t                quantity,
    input  wire price_t              price,
    input  wire id_t                 target_order,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic                is_quote,
    input  wire qty_t                trade_qty,
    input  wire price_t              trade_price,
    input  wire total_t              bid_qty,
    input  wire price_t              bid_price,
    input  wire total_t              ask_qty,
    input  wire logic [ASK_BITS-1:0] ask_price,
    input  wire logic                rejected,
    input  wire logic                last,
    output int                       fail_count,
    output int                       pending,
    output int                       trade_count,
    output int                       reject_count
);

    typedef struct packed {
        logic                is_quote;
        qty_t                trade_qty;
        price_t              trade_price;
        total_t              bid_qty;
        price_t              bid_price;
        total_t              ask_qty;
        logic [ASK_BITS-1:0] ask_price;
        logic                rejected;
        logic                last;
    } book_result_t;

    localparam logic [2:0] EMPTY_ASK_ADDR = {ADDR_EMPTY_ASK, 2'b00};

    // shadow book
    logic        slot_used  [ORDER_SLOTS];
    logic        slot_side  [ORDER_SLOTS];
    int unsigned slot_qty   [ORDER_SLOTS];
    int unsigned slot_price [ORDER_SLOTS];
    id_t         slot_id    [ORDER_SLOTS];
    int unsigned slot_next  [ORDER_SLOTS];
    int unsigned lvl_head   [2*PRICE_LEVELS];
    int unsigned lvl_tail   [2*PRICE_LEVELS];
    int unsigned lvl_total  [2*PRICE_LEVELS];
    logic        bid_ok, ask_ok;
    int unsigned bid_px, ask_px;
    id_t         next_id;
    logic [ASK_BITS-1:0] empty_ask;

    book_result_t expected_results[$];

    assign pending = expected_results.size();

    task automatic clear_book();
        for (int s = 0; s < ORDER_SLOTS; s++)
        begin
            slot_used[s] = 1'b0;
            slot_side[s] = 1'b0;
            slot_qty[s] = 0;
            slot_price[s] = 0;
            slot_id[s] = '0;
            slot_next[s] = 0;
        end
        for (int l = 0; l < 2*PRICE_LEVELS; l++)
        begin
            lvl_head[l] = 0;
            lvl_tail[l] = 0;
            lvl_total[l] = 0;
        end
        bid_ok = 1'b0;
        ask_ok = 1'b0;
        bid_px = 0;
        ask_px = 0;
        next_id = id_t'(1);
        empty_ask = EMPTY_ASK_RESET;
    endtask

    // best bid is the highest nonempty buy level, best ask the lowest nonempty sell level
    task automatic rescan_best();
        bid_ok = 1'b0;
        ask_ok = 1'b0;
        bid_px = 0;
        ask_px = 0;
        for (int p = 0; p < PRICE_LEVELS; p++)
        begin
            if (lvl_head[p] != 0)
            begin
                bid_ok = 1'b1;
                bid_px = p;
            end
        end
        for (int p = PRICE_LEVELS - 1; p >= 0; p--)
        begin
            if (lvl_head[PRICE_LEVELS + p] != 0)
            begin
                ask_ok = 1'b1;
                ask_px = p;
            end
        end
    endtask

    task automatic free_slot(input int unsigned s);
        slot_used[s] = 1'b0;
        slot_next[s] = 0;
    endtask

    // print all fields of one result
    task automatic show_result(input string tag, input book_result_t r);
        $display("%s q=%0b tq=%0d tp=%0d bq=%0d bp=%0d aq=%0d ap=%0d rj=%0b l=%0b",
                 tag, r.is_quote, r.trade_qty, r.trade_price, r.bid_qty, r.bid_price,
                 r.ask_qty, r.ask_price, r.rejected, r.last);
    endtask

    // match against the opposite side, then rest the remainder
    task automatic match_order(input logic side, input int unsigned qty_in,
                               input int unsigned px, input id_t oid, output logic rej);
        int unsigned qty, lp, idx, h, take, s;
        int n;
        book_result_t r;
        qty = qty_in;
        n = 0;
        rej = 1'b0;
        while (qty > 0)
        begin
            rescan_best();
            if (side == 1'b0)
            begin
                if (!ask_ok || ask_px > px)
                    break;
                lp = ask_px;
            end
            else
            begin
                if (!bid_ok || bid_px < px)
                    break;
                lp = bid_px;
            end
            idx = (side ? 0 : PRICE_LEVELS) + lp;
            h = lvl_head[idx];
            take = (slot_qty[h] < qty) ? slot_qty[h] : qty;
            slot_qty[h] -= take;
            lvl_total[idx] -= take;
            qty -= take;
            r = '{default: '0};
            r.trade_qty = qty_t'(take);
            r.trade_price = price_t'(lp);
            if (n < 63)
                expected_results.push_back(r);
            n++;
            if (slot_qty[h] == 0)
            begin
                lvl_head[idx] = slot_next[h];
                if (lvl_head[idx] == 0)
                begin
                    lvl_tail[idx] = 0;
                    lvl_total[idx] = 0;
                end
                free_slot(h);
            end
        end
        if (qty > 0)
        begin
            s = 0;
            for (int k = 1; k < ORDER_SLOTS; k++)
            begin
                if (!slot_used[k])
                begin
                    s = k;
                    break;
                end
            end
            if (s == 0)
                rej = 1'b1;
            else
            begin
                idx = (side ? PRICE_LEVELS : 0) + px;
                slot_used[s] = 1'b1;
                slot_side[s] = side;
                slot_qty[s] = qty;
                slot_price[s] = px;
                slot_id[s] = oid;
                slot_next[s] = 0;
                if (lvl_head[idx] == 0)
                    lvl_head[idx] = s;
                else
                    slot_next[lvl_tail[idx]] = s;
                lvl_tail[idx] = s;
                lvl_total[idx] = (lvl_total[idx] + qty) & 32'h3FFFFFF;
            end
        end
    endtask

    // remove the resting order with this id, lowest slot first
    task automatic cancel_order(input id_t tgt);
        int unsigned s, idx, cur, prev;
        s = ORDER_SLOTS;
        for (int k = 1; k < ORDER_SLOTS; k++)
        begin
            if (slot_used[k] && slot_id[k] == tgt)
            begin
                s = k;
                break;
            end
        end
        if (s < ORDER_SLOTS)
        begin
            idx = (slot_side[s] ? PRICE_LEVELS : 0) + slot_price[s];
            prev = 0;
            cur = lvl_head[idx];
            while (cur != 0 && cur != s)
            begin
                prev = cur;
                cur = slot_next[cur];
            end
            if (cur != 0)
            begin
                if (prev == 0)
                    lvl_head[idx] = slot_next[s];
                else
                    slot_next[prev] = slot_next[s];
                if (lvl_tail[idx] == s)
                    lvl_tail[idx] = prev;
                lvl_total[idx] -= slot_qty[s];
                if (lvl_head[idx] == 0)
                begin
                    lvl_tail[idx] = 0;
                    lvl_total[idx] = 0;
                end
                free_slot(s);
            end
        end
    endtask

    // one request: trades first, then the closing quote
    task automatic predict_request(input logic [1:0] t, input qty_t q, input price_t p,
                                   input id_t tgt);
        id_t oid;
        logic rej;
        book_result_t r;
        oid = next_id;
        rej = 1'b0;
        next_id = next_id + 1'b1;
        if (t == REQ_BUY || t == REQ_SELL)
        begin
            if (q != 0)
                match_order(t[0], q, p, oid, rej);
        end
        else if (t == REQ_CANCEL)
            cancel_order(tgt);
        rescan_best();
        r = '{default: '0};
        r.is_quote = 1'b1;
        if (bid_ok)
        begin
            r.bid_qty = total_t'(lvl_total[bid_px]);
            r.bid_price = price_t'(bid_px);
        end
        if (ask_ok)
        begin
            r.ask_qty = total_t'(lvl_total[PRICE_LEVELS + ask_px]);
            r.ask_price = ASK_BITS'(ask_px);
        end
        else
            r.ask_price = empty_ask;
        r.rejected = rej;
        r.last = 1'b1;
        expected_results.push_back(r);
    endtask

    // watch config writes, results and requests
    always @(posedge clk or negedge rst_n)
    begin
        book_result_t got, want;
        if (!rst_n)
        begin
            clear_book();
            expected_results.delete();
            fail_count <= 0;
            trade_count <= 0;
            reject_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == EMPTY_ASK_ADDR)
                empty_ask = pwdata[ASK_BITS-1:0];
            if (out_valid && out_ready)
            begin
                got = '{is_quote, trade_qty, trade_price, bid_qty, bid_price,
                        ask_qty, ask_price, rejected, last};
                if (!is_quote)
                    trade_count <= trade_count + 1;
                if (is_quote && rejected)
                    reject_count <= reject_count + 1;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: quote=%0b tq=%0d tp=%0d",
                                 is_quote, trade_qty, trade_price);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            show_result("mismatch exp:", want);
                            show_result("         act:", got);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_request(req_type, quantity, price, target_order);
        end
    end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench top: clock, reset, request and config stimulus, verdict
`default_nettype none

module testbench;
    import lome_pkg::*;

    localparam logic [1:0] REQ_OTHER      = 2'd3;
    localparam logic [2:0] EMPTY_ASK_ADDR = {ADDR_EMPTY_ASK, 2'b00};
    localparam int         IDLE_LIMIT     = 40000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0, in_ready;
    logic [1:0]          req_type = '0;
    qty_t                quantity = '0;
    price_t              price = '0;
    id_t                 target_order = '0;
    logic                out_valid, out_ready = 1'b0;
    logic                is_quote, rejected, last;
    qty_t                trade_qty;
    price_t              trade_price, bid_price;
    total_t              bid_qty, ask_qty;
    logic [ASK_BITS-1:0] ask_price;

    int   fail_count, pending, trade_count, reject_count;
    int   request_count = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    logic quiet = 1'b0;
    id_t  issued_id = id_t'(1);

    always #2 clk = ~clk;

    limit_order_matching_engine_core DUT (.*);

    book_checker checker_i (.*);

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left <= $urandom_range(1, 9);
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [1:0] t, input qty_t q, input price_t p,
                                input id_t tgt);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= t;
        quantity <= q;
        price <= p;
        target_order <= tgt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        request_count++;
        issued_id = issued_id + 1'b1;
    endtask

    // result queue must be drained before a register write
    task automatic write_empty_ask(input logic [ASK_BITS-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= EMPTY_ASK_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // random request; mode 0 trades around a narrow band, mode 1 builds a deep book
    task automatic random_request(input int mode);
        int     pick;
        logic [1:0] t;
        qty_t   q;
        price_t p;
        id_t    tgt;
        pick = $urandom_range(0, 99);
        t = (pick < 40) ? REQ_BUY : (pick < 80) ? REQ_SELL : (pick < 97) ? REQ_CANCEL : REQ_OTHER;
        q = qty_t'($urandom_range(1, 200));
        if ($urandom_range(0, 15) == 0)
            q = qty_t'($urandom);
        if ($urandom_range(0, 39) == 0)
            q = '0;
        if (mode == 0)
            p = price_t'(500 + $urandom_range(0, 20));
        else if (t == REQ_BUY)
            p = price_t'(400 + $urandom_range(0, 50));
        else
            p = price_t'(560 + $urandom_range(0, 60));
        if (mode == 1 && $urandom_range(0, 24) == 0)
        begin
            // sweep across many levels
            p = (t == REQ_BUY) ? PRICE_MAX : '0;
            q = qty_t'($urandom_range(2000, 20000));
        end
        if ($urandom_range(0, 19) == 0)
            p = price_t'($urandom);
        tgt = issued_id - id_t'($urandom_range(1, 40));
        if ($urandom_range(0, 9) == 0)
            tgt = id_t'($urandom);
        send_request(t, q, p, tgt);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty book, zero quantity, extremes, fifo order, cancels
        send_request(REQ_OTHER, '0, '0, '0);
        send_request(REQ_BUY, '0, price_t'(100), '0);
        send_request(REQ_SELL, '1, PRICE_MAX, '0);
        send_request(REQ_BUY, qty_t'(5), '0, '0);
        send_request(REQ_SELL, qty_t'(10), price_t'(600), '0);
        send_request(REQ_SELL, qty_t'(20), price_t'(600), '0);
        send_request(REQ_SELL, qty_t'(30), price_t'(601), '0);
        send_request(REQ_BUY, qty_t'(25), price_t'(600), '0);
        send_request(REQ_CANCEL, '0, '0, id_t'(5));
        send_request(REQ_CANCEL, '1, '1, id_t'(6));
        send_request(REQ_BUY, '1, PRICE_MAX, '0);
        send_request(REQ_CANCEL, '0, '0, id_t'(3));
        send_request(REQ_CANCEL, '0, '0, id_t'(4));
        send_request(REQ_SELL, qty_t'(1), '0, '0);
        send_request(REQ_BUY, qty_t'(1), PRICE_MAX, '0);
        send_request(REQ_CANCEL, '0, '0, '1);
        send_request(REQ_CANCEL, '0, '0, issued_id - 1'b1);

        write_empty_ask('0);
        repeat (150) random_request(0);

        write_empty_ask('1);
        repeat (150) random_request($urandom_range(0, 3) == 0 ? 0 : 1);

        write_empty_ask(ASK_BITS'($urandom));
        repeat (60) random_request(1);
        quiet = 1'b1;
        repeat (90) random_request($urandom_range(0, 1));
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d requests, %0d trades, %0d rejected remainders",
                 request_count, trade_count, reject_count);
        $display("empty ask register set to reset value, zero, all ones and a random value");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
